FILE: src/cbsd_pkg.sv
`timescale 1ns / 1ps

package cbsd_pkg;

   // Fixed planes and rounding constants of the dequantizer.
   localparam logic [4:0]  TOP_PLANE   = 5'd30;
   localparam logic [31:0] HALF_ROUND  = 32'h0000_8000;
   localparam int          ROUND_SHIFT = 16;
   localparam int          DOWN_SHIFT  = 15;
   localparam logic [31:0] DOWN_ROUND  = 32'd1 << (DOWN_SHIFT - 1);

   // Configuration register indexes.
   localparam int          CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAGNITUDE_BITS  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROI_SHIFT       = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REVERSIBLE_MODE = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_FACTOR    = 4'd3;

   // Reset values of the configuration registers.
   localparam logic [4:0]  RESET_MAGNITUDE_BITS  = 5'd30;
   localparam logic [4:0]  RESET_ROI_SHIFT       = 5'd0;
   localparam logic        RESET_REVERSIBLE_MODE = 1'b1;
   localparam logic [30:0] RESET_SCALE_FACTOR    = 31'd0;

   typedef struct packed {
      logic [4:0]  magnitude_bits;
      logic [4:0]  roi_shift;
      logic        reversible_mode;
      logic [30:0] scale_factor;
   } cfg_type;

   // Word handed from the front stage to the scaling stage.
   typedef struct packed {
      logic        reversible;
      logic        neg;
      logic [31:0] rev_value;
      logic [15:0] operand;
   } prep_type;

endpackage

FILE: src/codeblock_sample_dequantizer.sv
`timescale 1ns / 1ps
// Code-block sample dequantizer: sign-magnitude coefficient word in, signed sample out.
// Each accepted word passes through the input, middle and result registers before rsp_valid rises.
// Throughput: one word per cycle; each stage moves on when the stage after it is free.
// The multiply of the irreversible path sits in the back stage, between the middle and result registers.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module codeblock_sample_dequantizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [31:0]                          req_coeff_word,
   input  logic [7:0]                           req_state_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_dequant_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbsd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                          csr_data
);
   import cbsd_pkg::*;

   cfg_type     cfg;
   prep_type    prep;
   logic [31:0] result;

   // Pipeline registers.
   logic        in_valid_ff,  in_valid_in;
   logic [31:0] in_coeff_ff;
   logic [7:0]  in_state_ff;
   logic        mid_valid_ff, mid_valid_in;
   prep_type    mid_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_value_ff;

   logic        out_en;
   logic        mid_en;
   logic        in_en;

   // Configuration writes are always taken; the user must issue them only while idle, as the block does not enforce it.
   assign csr_ready = 1'b1;

   cbsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // A stage loads whenever it is empty or its word leaves in the same cycle, so a waiting
   // result holds back a stage in front of it only once every stage between them is full.
   assign out_en    = !out_valid_ff || rsp_ready;
   assign mid_en    = !mid_valid_ff || out_en;
   assign in_en     = !in_valid_ff || mid_en;
   assign req_ready = in_en;

   assign in_valid_in  = in_en  ? req_valid    : in_valid_ff;
   assign mid_valid_in = mid_en ? in_valid_ff  : mid_valid_ff;
   assign out_valid_in = out_en ? mid_valid_ff : out_valid_ff;

   // Front stage: sign strip, ROI upshift, plane count and midpoint bit, then
   // both the reversible shift and the 16-bit rounding of the scaled path.
   cbsd_prep u_prep (
      .coeff_word (in_coeff_ff),
      .state_byte (in_state_ff),
      .cfg        (cfg),
      .prep       (prep)
   );

   // Back stage: scale multiply, rounding downshift, sign restore and the choice of path by mode.
   cbsd_scale u_scale (
      .prep          (mid_ff),
      .scale_factor  (cfg.scale_factor),
      .dequant_value (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (in_en) begin
         in_coeff_ff <= req_coeff_word;
         in_state_ff <= req_state_byte;
      end
      if (mid_en) begin
         mid_ff <= prep;
      end
      if (out_en) begin
         out_value_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_dequant_value = $signed(out_value_ff);

endmodule

FILE: src/cbsd_csr.sv
`timescale 1ns / 1ps

module cbsd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [cbsd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                          csr_data,
   output cbsd_pkg::cfg_type                    cfg
);
   import cbsd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAGNITUDE_BITS:  cfg_in.magnitude_bits  = csr_data[4:0];
            CSR_ROI_SHIFT:       cfg_in.roi_shift       = csr_data[4:0];
            CSR_REVERSIBLE_MODE: cfg_in.reversible_mode = csr_data[0];
            CSR_SCALE_FACTOR:    cfg_in.scale_factor    = csr_data[30:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magnitude_bits  <= RESET_MAGNITUDE_BITS;
         cfg_ff.roi_shift       <= RESET_ROI_SHIFT;
         cfg_ff.reversible_mode <= RESET_REVERSIBLE_MODE;
         cfg_ff.scale_factor    <= RESET_SCALE_FACTOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/cbsd_prep.sv
`timescale 1ns / 1ps

module cbsd_prep (
   input  logic [31:0]        coeff_word,
   input  logic [7:0]         state_byte,
   input  cbsd_pkg::cfg_type  cfg,
   output cbsd_pkg::prep_type prep
);
   import cbsd_pkg::*;

   logic [4:0]  mb;
   logic [4:0]  plsb;
   logic [5:0]  mb_plus;
   logic [31:0] lowmask;
   logic        roi_en;
   logic [31:0] mag;
   logic [31:0] val;
   logic [4:0]  nb;
   logic [4:0]  rshift;
   logic [31:0] rbit;
   logic        nonzero;
   logic [31:0] rev_mag;
   logic [31:0] rev_signed;
   logic [31:0] irr_mag;
   logic [31:0] irr_sum;

   // Out-of-range plane counts are pulled back into 1..30.
   always_comb begin
      if (cfg.magnitude_bits == 5'd0) begin
         mb = 5'd1;
      end else if (cfg.magnitude_bits > TOP_PLANE) begin
         mb = TOP_PLANE;
      end else begin
         mb = cfg.magnitude_bits;
      end
   end

   assign plsb    = 5'd31 - mb;
   assign mb_plus = {1'b0, mb} + 6'd1;
   assign lowmask = 32'hFFFF_FFFF >> mb_plus;
   assign roi_en  = (cfg.roi_shift != 5'd0);
   assign mag     = {1'b0, coeff_word[30:0]};

   // Max-shift upshift only for background samples with no high planes set.
   assign val = (roi_en && ((mag & ~lowmask) == 32'd0)) ? (mag << cfg.roi_shift) : mag;

   assign nb = roi_en ? mb : (5'd31 - state_byte[7:3]);

   // Midpoint bit sits one below the lowest decoded plane.
   assign rshift  = (mb > nb) ? (TOP_PLANE - nb) : (TOP_PLANE - mb);
   assign rbit    = 32'd1 << rshift;
   assign nonzero = (val != 32'd0);

   assign rev_mag    = (nonzero && (nb < mb)) ? (val | rbit) : val;
   assign rev_signed = coeff_word[31] ? (32'd0 - rev_mag) : rev_mag;

   assign irr_mag = nonzero ? (val | rbit) : val;
   assign irr_sum = irr_mag + HALF_ROUND;

   always_comb begin
      prep.reversible = cfg.reversible_mode;
      prep.neg        = coeff_word[31];
      prep.rev_value  = 32'($signed(rev_signed) >>> plsb);
      prep.operand    = irr_sum[31:ROUND_SHIFT];
   end

endmodule

FILE: src/cbsd_scale.sv
`timescale 1ns / 1ps

module cbsd_scale (
   input  cbsd_pkg::prep_type prep,
   input  logic [30:0]        scale_factor,
   output logic [31:0]        dequant_value
);
   import cbsd_pkg::*;

   logic [31:0] op_ext;
   logic [31:0] product;
   logic [31:0] rounded;
   logic [31:0] shifted;
   logic [31:0] irr_value;

   // Low 32 bits of the signed operand times the unsigned scale.
   assign op_ext  = {{16{prep.operand[15]}}, prep.operand};
   assign product = op_ext * {1'b0, scale_factor};
   assign rounded = product + DOWN_ROUND;
   assign shifted = {{DOWN_SHIFT{rounded[31]}}, rounded[31:DOWN_SHIFT]};

   assign irr_value     = prep.neg ? (32'd0 - shifted) : shifted;
   assign dequant_value = prep.reversible ? prep.rev_value : irr_value;

endmodule

FILE: tb/dequant_checker.sv
`timescale 1ns / 1ps

// Watches the register, coefficient and result channels of the dequantizer,
// predicts every sample from its own copy of the registers and compares in order.
module dequant_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [31:0]                          req_coeff_word,
   input  logic [7:0]                           req_state_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [31:0]                   rsp_dequant_value,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [cbsd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                          csr_data,
   output int                                   errors,
   output int                                   pending,
   output int                                   checked
);
   import cbsd_pkg::*;

   cfg_type     setting;
   logic [31:0] expected_samples[$];
   logic [31:0] wanted;
   int          error_total   = 0;
   int          checked_total = 0;

   function automatic logic [31:0] dequantize_sample(input cfg_type s,
                                                     input logic [31:0] coeff,
                                                     input logic [7:0] state);
      int unsigned mb, plsb, planes, offset;
      logic        neg;
      logic [31:0] low_mask, mag, recon_bit, acc;
      mb = 32'(s.magnitude_bits);
      if (mb < 1) mb = 1;
      if (mb > TOP_PLANE) mb = 32'(TOP_PLANE);
      plsb     = 31 - mb;
      low_mask = 32'hFFFF_FFFF >> (mb + 1);
      neg      = coeff[31];
      mag      = {1'b0, coeff[30:0]};
      // Background samples under ROI carry no bits above the subband planes.
      if (s.roi_shift != 0 && (mag & ~low_mask) == 32'd0) mag = mag << s.roi_shift;
      if (s.roi_shift != 0) planes = mb;
      else planes = TOP_PLANE + 1 - state[7:3];
      offset    = (mb > planes) ? mb - planes : 0;
      recon_bit = 32'd1 << (plsb - 1 + offset);
      if (s.reversible_mode) begin
         if (mag != 32'd0 && planes < mb) mag = mag | recon_bit;
         if (neg) mag = -mag;
         return $signed(mag) >>> plsb;
      end
      if (mag != 32'd0) mag = mag | recon_bit;
      acc = $signed(mag + HALF_ROUND) >>> ROUND_SHIFT;
      acc = acc * {1'b0, s.scale_factor};
      acc = $signed(acc + DOWN_ROUND) >>> DOWN_SHIFT;
      return neg ? -acc : acc;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         setting.magnitude_bits  = RESET_MAGNITUDE_BITS;
         setting.roi_shift       = RESET_ROI_SHIFT;
         setting.reversible_mode = RESET_REVERSIBLE_MODE;
         setting.scale_factor    = RESET_SCALE_FACTOR;
         expected_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAGNITUDE_BITS:  setting.magnitude_bits  = csr_data[4:0];
               CSR_ROI_SHIFT:       setting.roi_shift       = csr_data[4:0];
               CSR_REVERSIBLE_MODE: setting.reversible_mode = csr_data[0];
               CSR_SCALE_FACTOR:    setting.scale_factor    = csr_data[30:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("dequant_value: got %0d with no word outstanding", rsp_dequant_value);
               error_total++;
            end else begin
               wanted = expected_samples.pop_front();
               checked_total++;
               if (rsp_dequant_value !== wanted) begin
                  $error("dequant_value mismatch: expected %0d, actual %0d",
                         $signed(wanted), rsp_dequant_value);
                  error_total++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_samples.push_back(dequantize_sample(setting, req_coeff_word,
                                                         req_state_byte));
      end
      errors  <= error_total;
      pending <= expected_samples.size();
      checked <= checked_total;
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the code-block sample dequantizer. All prediction and
// comparison lives in the checker, which hands back its error and pending counts.
module tb_top;
   import cbsd_pkg::*;

   // The run is ended by force well beyond the slowest correct run.
   localparam int CYCLE_LIMIT  = 200000;
   // Length of the deliberate receiver hold-off, long enough to fill the pipeline.
   localparam int HOLD_CYCLES  = 300;
   // Cycles to let pass after the last result, before registers are written or the verdict given.
   localparam int SETTLE       = 6;
   // An index no register answers to; a write there must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 4'hF;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_ready;
   logic [31:0]                req_coeff_word    = 32'd0;
   logic [7:0]                 req_state_byte    = 8'd0;
   logic                       rsp_valid;
   logic                       rsp_ready         = 1'b0;
   logic signed [31:0]         rsp_dequant_value;
   logic                       csr_valid         = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index         = '0;
   logic [31:0]                csr_data          = 32'd0;

   int      errors, pending, checked;
   int      cycle_count    = 0;
   int      send_idle_pct  = 11;
   int      recv_idle_pct  = 49;
   int      hold_left      = 0;
   logic    hold_request   = 1'b0;
   logic    hold_served    = 1'b0;
   int      settings_used  = 0;
   cfg_type current;

   always #1 clock = ~clock;

   codeblock_sample_dequantizer dut (.*);

   dequant_checker u_checker (.*);

   // The run is abandoned if it has not finished within the cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Result side. It stalls at random, and once, on request, holds off for a long
   // stretch that it counts itself, so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_served) begin
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_served <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offers one coefficient word, after a random gap, and returns at the edge at
   // which it is taken. Valid is left high so that the next word can follow at once.
   task automatic send_word(input logic [31:0] coeff, input logic [7:0] state);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_coeff_word <= coeff;
      req_state_byte <= state;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering words and waits until the checker has seen every result.
   // The first edge lets the count take in a word taken at the current edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Registers are only written once the block is empty. Bits above each register's
   // width carry random junk, which the block must ignore.
   task automatic apply_setting(input cfg_type s);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      write_csr(CSR_UNUSED_INDEX, $urandom());
      write_csr(CSR_MAGNITUDE_BITS, ($urandom() & ~32'h1F) | s.magnitude_bits);
      write_csr(CSR_ROI_SHIFT, ($urandom() & ~32'h1F) | s.roi_shift);
      write_csr(CSR_REVERSIBLE_MODE, ($urandom() & ~32'h1) | s.reversible_mode);
      write_csr(CSR_SCALE_FACTOR, ($urandom() & 32'h8000_0000) | s.scale_factor);
      csr_valid <= 1'b0;
      current = s;
      settings_used++;
   endtask

   // A random setting that lands on the extremes of each register fairly often,
   // including the out-of-range plane counts that the block must clamp.
   function automatic cfg_type random_setting();
      cfg_type s;
      case ($urandom_range(5))
         0: s.magnitude_bits = 5'd0;
         1: s.magnitude_bits = 5'd1;
         2: s.magnitude_bits = 5'd30;
         3: s.magnitude_bits = 5'd31;
         default: s.magnitude_bits = 5'($urandom_range(29, 2));
      endcase
      s.roi_shift       = $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 1));
      s.reversible_mode = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: s.scale_factor = 31'h7FFF_FFFF;
         1: s.scale_factor = 31'($urandom_range(65536));
         default: s.scale_factor = 31'($urandom());
      endcase
      return s;
   endfunction

   function automatic int unsigned planes_of(input cfg_type s);
      if (s.magnitude_bits < 1) return 1;
      if (s.magnitude_bits > TOP_PLANE) return 32'(TOP_PLANE);
      return 32'(s.magnitude_bits);
   endfunction

   // Most words are well formed: the magnitude sits in the subband's top planes,
   // or, under ROI, entirely below them so that the upshift applies. The remainder
   // are zero magnitudes and unrestricted noise.
   function automatic logic [31:0] make_coeff(input cfg_type s);
      int unsigned mb, pick;
      logic [31:0] mag;
      logic        sign;
      mb   = planes_of(s);
      pick = $urandom_range(99);
      mag  = $urandom() & 32'h7FFF_FFFF;
      sign = 1'($urandom_range(1));
      if (pick < 50)
         mag = mag & ((32'h7FFF_FFFF >> (31 - mb)) << (31 - mb));
      else if (pick < 72)
         mag = mag & (32'hFFFF_FFFF >> (mb + 1 + $urandom_range(mb)));
      else if (pick < 82)
         mag = 32'd0;
      return {sign, mag[30:0]};
   endfunction

   // The missing plane count mostly stays within the subband's planes.
   function automatic logic [7:0] make_state(input cfg_type s);
      logic [4:0] missing;
      logic [2:0] rest;
      rest = 3'($urandom());
      if ($urandom_range(99) < 70) missing = 5'($urandom_range(planes_of(s)));
      else missing = 5'($urandom());
      return {missing, rest};
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_word(make_coeff(current), make_state(current));
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      current = '{magnitude_bits: RESET_MAGNITUDE_BITS, roi_shift: RESET_ROI_SHIFT,
                  reversible_mode: RESET_REVERSIBLE_MODE, scale_factor: RESET_SCALE_FACTOR};
      @(posedge clock);

      // Reset setting: reversible, full planes, no ROI. Zero and negative zero,
      // the largest magnitudes of both signs, and missing counts at both ends.
      send_word(32'h0000_0000, 8'h00);
      send_word(32'h8000_0000, 8'hFF);
      send_word(32'h7FFF_FFFF, 8'h00);
      send_word(32'hFFFF_FFFF, 8'hF8);
      send_word(32'h0000_0001, 8'h08);
      send_word(32'hC000_0000, 8'h37);
      send_word(32'h4000_0000, 8'hF0);

      // A plane count of zero acts as one; the widest ROI shift pushes a single bit
      // into bit 31, and that value must still count as nonzero.
      apply_setting('{magnitude_bits: 5'd0, roi_shift: 5'd31, reversible_mode: 1'b1,
                      scale_factor: 31'd12345});
      send_word(32'h0000_0001, 8'h00);
      send_word(32'h8000_0001, 8'hFF);
      send_word(32'h7FFF_FFFF, 8'h00);

      // A plane count of 31 acts as 30; the largest scale makes the product wrap.
      apply_setting('{magnitude_bits: 5'd31, roi_shift: 5'd1, reversible_mode: 1'b0,
                      scale_factor: 31'h7FFF_FFFF});
      send_word(32'h7FFF_FFFF, 8'h00);
      send_word(32'hFFFF_FFFF, 8'hFF);
      send_word(32'h0000_0000, 8'h00);
      send_word(32'h8000_0000, 8'h00);
      send_word(32'h0000_0003, 8'h00);

      // Irreversible path at unity scale with a mid-range plane count.
      apply_setting('{magnitude_bits: 5'd15, roi_shift: 5'd0, reversible_mode: 1'b0,
                      scale_factor: 31'h0000_8000});
      send_word(32'h1234_5678, 8'h48);
      send_word(32'h9234_5678, 8'h78);
      send_word(32'h0000_FFFF, 8'hF8);

      // Random part in three idling regimes, two register settings each. The result
      // side is given a long hold-off in the last regime while words keep coming.
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin send_idle_pct = 11; recv_idle_pct <= 49; end
            1: begin send_idle_pct = 49; recv_idle_pct <= 11; end
            default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
         endcase
         for (int part = 0; part < 2; part++) begin
            apply_setting(random_setting());
            if (regime == 2 && part == 1) hold_request <= 1'b1;
            send_random(165);
            // Halfway through the first setting of the second regime, the sender pauses until the block has emptied.
            if (regime == 1 && part == 0) wait_drained();
            send_random(165);
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("Checked %0d dequantized samples over %0d register settings,",
               checked, settings_used);
      $display("under three idling regimes and one long result-side hold-off.");
      if (errors == 0 && pending == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
